// ===== hdl/tvmf_pkg.sv =====
// ----------------------------------------------------------------------------
// tvmf_pkg: shared constants and types
// Register codes, frame limits and the result side-band type of the filter.
// ----------------------------------------------------------------------------
package tvmf_pkg;

    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int CHANNEL_BITS_DEF = 8;

    localparam int WIN_N      = 9;     // window pixels
    localparam int SEL_N      = 3;     // pixels kept for the mean
    localparam int IDX_W      = 4;     // window position index
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;

    localparam int ROW_W     = 12;
    localparam int OUT_COL_W = 11;
    localparam int FW_W      = 12;
    localparam int FH_W      = 13;

    localparam int FW_RESET = 640;
    localparam int FH_RESET = 480;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    typedef struct packed {
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } meta_t;

    localparam int META_W = $bits(meta_t);

endpackage

// ===== hdl/tvmf_ram.sv =====
// ----------------------------------------------------------------------------
// tvmf_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tvmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/tvmf_queue.sv =====
// ----------------------------------------------------------------------------
// tvmf_queue: two-entry request queue
// Decouples window building from the scoring pipeline.
// ----------------------------------------------------------------------------
module tvmf_queue #(
    parameter int WIDTH = 240
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] data_reg [2];
    logic [1:0]       count_reg;
    logic             wp_reg;
    logic             rp_reg;
    logic             push_acc;
    logic             pop_acc;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = data_reg[rp_reg];
    assign push_acc   = push_valid && push_ready;
    assign pop_acc    = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
        end
        else
        begin
            if (push_acc)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop_acc)
            begin
                rp_reg <= !rp_reg;
            end
            if (push_acc && !pop_acc)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop_acc && !push_acc)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            data_reg[wp_reg] <= push_data;
        end
    end

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push_acc && !pop_acc) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count did not follow a lone push");

endmodule

// ===== hdl/tvmf_front.sv =====
// ----------------------------------------------------------------------------
// tvmf_front: pixel intake, line stores and 3x3 window
// Tracks raster position, keeps two rows of history, issues window requests.
// ----------------------------------------------------------------------------
module tvmf_front #(
    parameter int MAX_WIDTH    = tvmf_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = tvmf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tvmf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tvmf_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [CHANNEL_BITS-1:0]               red,
    input  logic [CHANNEL_BITS-1:0]               green,
    input  logic [CHANNEL_BITS-1:0]               blue,
    output logic                                  q_valid,
    input  logic                                  q_ready,
    output logic [8:0][3*CHANNEL_BITS-1:0]        q_win,
    output tvmf_pkg::meta_t                       q_meta
);

    localparam int PIX_W = 3 * CHANNEL_BITS;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WC_W  = $clog2(MAX_WIDTH + 1);
    localparam int FW_W  = tvmf_pkg::FW_W;
    localparam int FH_W  = tvmf_pkg::FH_W;
    localparam int ROW_W = tvmf_pkg::ROW_W;

    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;
    logic [WC_W-1:0]  eff_w;
    logic [FH_W-1:0]  eff_h;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] cur_c;
    logic [ROW_W-1:0] cur_r;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic [WC_W-1:0]  c_inc;
    logic [FH_W-1:0]  r_inc;
    logic [31:0]      c_m1;
    logic [31:0]      r_m1;

    logic             in_acc;
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic [COL_W-1:0] s1_c_reg;
    logic [PIX_W-1:0] s1_px_reg;
    tvmf_pkg::meta_t  s1_meta_reg;
    logic             s1_adv;

    logic [PIX_W-1:0] up_rd;
    logic [PIX_W-1:0] lo_rd;

    logic [8:0][PIX_W-1:0] win_reg;
    logic [8:0][PIX_W-1:0] win_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_W'(tvmf_pkg::FW_RESET);
            fh_reg <= FH_W'(tvmf_pkg::FH_RESET);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tvmf_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                tvmf_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (fw_reg < FW_W'(tvmf_pkg::MIN_DIM))
            eff_w = WC_W'(tvmf_pkg::MIN_DIM);
        else if (32'(fw_reg) > MAX_WIDTH)
            eff_w = WC_W'(MAX_WIDTH);
        else
            eff_w = WC_W'(fw_reg);

        if (fh_reg < FH_W'(tvmf_pkg::MIN_DIM))
            eff_h = FH_W'(tvmf_pkg::MIN_DIM);
        else if (32'(fh_reg) > tvmf_pkg::MAX_HEIGHT)
            eff_h = FH_W'(tvmf_pkg::MAX_HEIGHT);
        else
            eff_h = fh_reg;
    end

    // raster position, wrapped against the current limits
    always_comb
    begin
        cur_c = (WC_W'(col_reg) >= eff_w) ? '0 : col_reg;
        cur_r = (FH_W'(row_reg) >= eff_h) ? '0 : row_reg;
        c_inc = WC_W'(cur_c) + WC_W'(1);
        r_inc = FH_W'(cur_r) + FH_W'(1);
        if (c_inc >= eff_w)
        begin
            col_next = '0;
            row_next = (r_inc >= eff_h) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = cur_r;
        end
        c_m1 = 32'(cur_c) - 32'd1;
        r_m1 = 32'(cur_r) - 32'd1;
    end

    assign in_acc   = in_valid && in_ready;
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || q_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_c_reg         <= cur_c;
            s1_px_reg        <= {blue, green, red};
            s1_emit_reg      <= (cur_r >= ROW_W'(2)) && (cur_c >= COL_W'(2));
            s1_meta_reg.col  <= c_m1[tvmf_pkg::OUT_COL_W-1:0];
            s1_meta_reg.row  <= r_m1[ROW_W-1:0];
            s1_meta_reg.last <= (FH_W'(cur_r) == eff_h - FH_W'(1)) &&
                                (WC_W'(cur_c) == eff_w - WC_W'(1));
        end
    end

    // line stores: read on intake, written back as the pixel leaves stage 1
    tvmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_c_reg),
        .wr_data (lo_rd),
        .rd_en   (in_acc),
        .rd_addr (cur_c),
        .rd_data (up_rd)
    );

    tvmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_c_reg),
        .wr_data (s1_px_reg),
        .rd_en   (in_acc),
        .rd_addr (cur_c),
        .rd_data (lo_rd)
    );

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3+1];
            win_next[r*3+1]   = win_reg[r*3+2];
        end
        win_next[2] = up_rd;
        win_next[5] = lo_rd;
        win_next[8] = s1_px_reg;
    end

    assign q_valid = s1_valid_reg && s1_emit_reg;
    assign q_win   = win_next;
    assign q_meta  = s1_meta_reg;

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && in_acc) |-> (s1_c_reg != cur_c))
        else $error("line store read and write hit the same column");

endmodule

// ===== hdl/tvmf_back.sv =====
// ----------------------------------------------------------------------------
// tvmf_back: scoring, selection and mean pipeline
// Seven stages: distances, scores, three selection passes, sums, mean.
// ----------------------------------------------------------------------------
module tvmf_back #(
    parameter int CHANNEL_BITS = tvmf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [8:0][3*CHANNEL_BITS-1:0] in_win,
    input  tvmf_pkg::meta_t                in_meta,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [CHANNEL_BITS+1:0]        red_mean,
    output logic [CHANNEL_BITS+1:0]        green_mean,
    output logic [CHANNEL_BITS+1:0]        blue_mean,
    output logic [tvmf_pkg::OUT_COL_W-1:0] out_col,
    output logic [tvmf_pkg::ROW_W-1:0]     out_row,
    output logic                           last_of_frame
);

    localparam int CB    = CHANNEL_BITS;
    localparam int PIX_W = 3 * CB;
    localparam int N     = tvmf_pkg::WIN_N;
    localparam int NS    = tvmf_pkg::SEL_N;
    localparam int IW    = tvmf_pkg::IDX_W;
    localparam int DW    = CB + 2;
    localparam int SW    = DW + 3;
    localparam int SUM_W = CB + 2;
    localparam int X_W   = SUM_W + 2;
    localparam int K     = X_W + 2;
    localparam int RECIP = ((1 << K) + 2) / 3;
    localparam int MUL_W = X_W + K;
    localparam int OUT_W = CB + 2;
    localparam int NST   = 7;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [N-1:0]     win_t;

    function automatic logic [CB-1:0] absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    logic [NST-1:0] vld_reg;
    logic           en;

    assign en        = !vld_reg[NST-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // stage 1: pairwise L1 distances
    logic [DW-1:0]   d_next [N][N];
    logic [DW-1:0]   d1_reg [N][N];
    win_t            w1_reg;
    tvmf_pkg::meta_t m1_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
            begin
                d_next[i][j] = '0;
                if (i < j)
                begin
                    d_next[i][j] =
                        DW'(absdiff(in_win[i][0*CB +: CB], in_win[j][0*CB +: CB])) +
                        DW'(absdiff(in_win[i][1*CB +: CB], in_win[j][1*CB +: CB])) +
                        DW'(absdiff(in_win[i][2*CB +: CB], in_win[j][2*CB +: CB]));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= d_next;
            w1_reg <= in_win;
            m1_reg <= in_meta;
        end
    end

    // stage 2: scores
    logic [SW-1:0]   sc_next [N];
    logic [SW-1:0]   sc2_reg [N];
    win_t            w2_reg;
    tvmf_pkg::meta_t m2_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            sc_next[i] = '0;
            for (int j = 0; j < N; j++)
            begin
                if (i < j)
                    sc_next[i] = sc_next[i] + SW'(d1_reg[i][j]);
                else if (j < i)
                    sc_next[i] = sc_next[i] + SW'(d1_reg[j][i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc2_reg <= sc_next;
            w2_reg  <= w1_reg;
            m2_reg  <= m1_reg;
        end
    end

    // stages 3..5: one selection-sort pass each, scores travel with positions
    logic [IW-1:0]   pos_reg [NS][N];
    logic [SW-1:0]   ssc_reg [NS][N];
    win_t            sw_reg  [NS];
    tvmf_pkg::meta_t sm_reg  [NS];

    for (genvar p = 0; p < NS; p++)
    begin : g_pass
        logic [IW-1:0]   src_pos [N];
        logic [SW-1:0]   src_sc  [N];
        win_t            src_w;
        tvmf_pkg::meta_t src_m;
        logic [IW-1:0]   npos    [N];
        logic [SW-1:0]   nsc     [N];
        logic [IW-1:0]   mi;

        if (p == 0)
        begin : g_first
            always_comb
            begin
                for (int j = 0; j < N; j++)
                begin
                    src_pos[j] = IW'(j);
                    src_sc[j]  = sc2_reg[j];
                end
                src_w = w2_reg;
                src_m = m2_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int j = 0; j < N; j++)
                begin
                    src_pos[j] = pos_reg[p-1][j];
                    src_sc[j]  = ssc_reg[p-1][j];
                end
                src_w = sw_reg[p-1];
                src_m = sm_reg[p-1];
            end
        end

        always_comb
        begin
            mi = IW'(p);
            for (int j = p + 1; j < N; j++)
            begin
                if (src_sc[j] < src_sc[mi])
                    mi = IW'(j);
            end
            for (int j = 0; j < N; j++)
            begin
                npos[j] = src_pos[j];
                nsc[j]  = src_sc[j];
            end
            npos[p]  = src_pos[mi];
            nsc[p]   = src_sc[mi];
            npos[mi] = src_pos[p];
            nsc[mi]  = src_sc[p];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pos_reg[p] <= npos;
                ssc_reg[p] <= nsc;
                sw_reg[p]  <= src_w;
                sm_reg[p]  <= src_m;
            end
        end
    end

    // stage 6: channel sums of the three chosen pixels
    logic [SUM_W-1:0] sum_next [3];
    logic [SUM_W-1:0] sum6_reg [3];
    tvmf_pkg::meta_t  m6_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_next[k] = '0;
            for (int s = 0; s < NS; s++)
                sum_next[k] = sum_next[k] +
                    SUM_W'(sw_reg[NS-1][pos_reg[NS-1][s]][k*CB +: CB]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum6_reg <= sum_next;
            m6_reg   <= sm_reg[NS-1];
        end
    end

    // stage 7: (4*sum + 1) / 3 by reciprocal multiply
    logic [X_W-1:0]   x_val  [3];
    logic [MUL_W-1:0] prod   [3];
    logic [OUT_W-1:0] mean_reg [3];
    tvmf_pkg::meta_t  m7_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            x_val[k] = {sum6_reg[k], 2'b00} + X_W'(1);
            prod[k]  = MUL_W'(x_val[k]) * MUL_W'(RECIP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                mean_reg[k] <= prod[k][K +: OUT_W];
            m7_reg <= m6_reg;
        end
    end

    assign red_mean      = mean_reg[0];
    assign green_mean    = mean_reg[1];
    assign blue_mean     = mean_reg[2];
    assign out_col       = m7_reg.col;
    assign out_row       = m7_reg.row;
    assign last_of_frame = m7_reg.last;

    a_sel_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (pos_reg[NS-1][0] != pos_reg[NS-1][1]) &&
                       (pos_reg[NS-1][0] != pos_reg[NS-1][2]) &&
                       (pos_reg[NS-1][1] != pos_reg[NS-1][2]))
        else $error("selection picked one pixel twice");

    a_sel_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (ssc_reg[NS-1][0] <= ssc_reg[NS-1][1]) &&
                       (ssc_reg[NS-1][1] <= ssc_reg[NS-1][2]))
        else $error("selected scores out of order");

endmodule

// ===== hdl/trimmed_vector_median_filter_3x3_top.sv =====
// ----------------------------------------------------------------------------
// trimmed_vector_median_filter_3x3_top: alpha-trimmed vector median, 3x3
// Raster RGB in, mean of the three most central window pixels out (Q8.2).
// ----------------------------------------------------------------------------
//
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------------
// in       | in_valid / in_ready    | red, green, blue
// out      | out_valid / out_ready  | red_mean, green_mean, blue_mean, out_col,
//          |                        | out_row, last_of_frame
// cfg      | cfg_valid / cfg_ready  | cfg_index (0 width, 1 height), cfg_data
//
// Throughput is one pixel per clock while the queue has room; the line stores
// are read when a pixel is taken and written back as it leaves the intake stage.
// From pixel request to result the data passes the intake stage, the queue,
// then seven stages of distance, score, three selection passes, sum, mean.
// Reset is asynchronous and active low; it clears position counters, window
// and valids. Line stores are not cleared. No clearing pass is needed.
// A two-entry queue separates intake from scoring, so a stalled output only
// holds off input once the queue is full.
// Border pixels produce no result request.
//
module trimmed_vector_median_filter_3x3_top #(
    parameter int MAX_WIDTH    = tvmf_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = tvmf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tvmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [CHANNEL_BITS-1:0]         red,
    input  logic [CHANNEL_BITS-1:0]         green,
    input  logic [CHANNEL_BITS-1:0]         blue,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [CHANNEL_BITS+1:0]         red_mean,
    output logic [CHANNEL_BITS+1:0]         green_mean,
    output logic [CHANNEL_BITS+1:0]         blue_mean,
    output logic [tvmf_pkg::OUT_COL_W-1:0]  out_col,
    output logic [tvmf_pkg::ROW_W-1:0]      out_row,
    output logic                            last_of_frame
);

    localparam int PIX_W = 3 * CHANNEL_BITS;
    localparam int Q_W   = 9 * PIX_W + tvmf_pkg::META_W;

    // intake -> queue
    logic                  fq_valid;
    logic                  fq_ready;
    logic [8:0][PIX_W-1:0] fq_win;
    tvmf_pkg::meta_t       fq_meta;

    // queue -> scoring
    logic                  qb_valid;
    logic                  qb_ready;
    logic [Q_W-1:0]        qb_data;
    logic [8:0][PIX_W-1:0] qb_win;
    tvmf_pkg::meta_t       qb_meta;

    tvmf_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_win     (fq_win),
        .q_meta    (fq_meta)
    );

    tvmf_queue #(.WIDTH(Q_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  ({fq_win, fq_meta}),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    assign {qb_win, qb_meta} = qb_data;

    tvmf_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_win        (qb_win),
        .in_meta       (qb_meta),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red_mean      (red_mean),
        .green_mean    (green_mean),
        .blue_mean     (blue_mean),
        .out_col       (out_col),
        .out_row       (out_row),
        .last_of_frame (last_of_frame)
    );

endmodule

// ===== test/trimmed_vector_median_filter_3x3_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_vector_median_filter_3x3_top_tb: self-checking bench for the filter
// Streams RGB frames of varied size, predicts each trimmed mean and compares
// every result request field by field under random idling and stalling.
// ----------------------------------------------------------------------------
module trimmed_vector_median_filter_3x3_top_tb;

    typedef logic [2:0][7:0] rgb_t;   // [0] red, [1] green, [2] blue

    typedef struct packed {
        logic [9:0]  red_m;
        logic [9:0]  green_m;
        logic [9:0]  blue_m;
        logic [10:0] col;
        logic [11:0] row;
        logic        last;
    } mean_res_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [tvmf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tvmf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [7:0]                      red, green, blue;
    logic                            out_valid;
    logic                            out_ready;
    logic [9:0]                      red_mean, green_mean, blue_mean;
    logic [10:0]                     out_col;
    logic [11:0]                     out_row;
    logic                            last_of_frame;

    trimmed_vector_median_filter_3x3_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .red(red), .green(green), .blue(blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_mean(red_mean), .green_mean(green_mean), .blue_mean(blue_mean),
        .out_col(out_col), .out_row(out_row), .last_of_frame(last_of_frame)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---- shadow of the filter state ----
    rgb_t      upper_row [2048];
    rgb_t      lower_row [2048];
    rgb_t      win [9];
    int        col_pos, row_pos;
    int        width_reg, height_reg;
    mean_res_t pending_means [$];

    int error_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int idle_cnt = 0;

    // palette for tie-heavy windows
    rgb_t palette [3];

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic int abs_diff(input int a, input int b);
        return a > b ? a - b : b - a;
    endfunction

    // Apply a register write to the shadow copy (width keeps 12 bits only).
    task automatic shadow_config(input logic [tvmf_pkg::CFG_IDX_W-1:0] idx, input int value);
        if (idx == tvmf_pkg::REG_FRAME_WIDTH)
            width_reg = value & 12'hFFF;
        else
            height_reg = value & 13'h1FFF;
    endtask

    // Work out the trimmed mean caused by one accepted pixel, if any.
    task automatic predict_mean(input rgb_t px);
        int w, h, c, r, m, t, d;
        int score [9];
        int pos [9];
        int sum [3];
        rgb_t up, lo;
        mean_res_t res;
        w = (width_reg < tvmf_pkg::MIN_DIM) ? tvmf_pkg::MIN_DIM :
            (width_reg > 2048 ? 2048 : width_reg);
        h = (height_reg < tvmf_pkg::MIN_DIM) ? tvmf_pkg::MIN_DIM :
            (height_reg > tvmf_pkg::MAX_HEIGHT ? tvmf_pkg::MAX_HEIGHT : height_reg);
        // counters beyond a freshly lowered limit wrap independently
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        up = upper_row[c];
        lo = lower_row[c];
        for (int i = 0; i < 3; i++)
        begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = px;
        upper_row[c] = lo;
        lower_row[c] = px;
        if (r >= 2 && c >= 2)
        begin
            for (int i = 0; i < 9; i++)
            begin
                score[i] = 0;
                pos[i] = i;
            end
            for (int i = 0; i < 9; i++)
                for (int j = i + 1; j < 9; j++)
                begin
                    d = 0;
                    for (int k = 0; k < 3; k++)
                        d += abs_diff(win[i][k], win[j][k]);
                    score[i] += d;
                    score[j] += d;
                end
            // three passes of a selection sort, strict less-than keeps order on ties
            for (int i = 0; i < 3; i++)
            begin
                m = i;
                for (int j = i + 1; j < 9; j++)
                    if (score[pos[j]] < score[pos[m]]) m = j;
                t = pos[i];
                pos[i] = pos[m];
                pos[m] = t;
            end
            for (int k = 0; k < 3; k++)
            begin
                sum[k] = 0;
                for (int i = 0; i < 3; i++)
                    sum[k] += win[pos[i]][k];
            end
            res.red_m   = 10'((4 * sum[0] + 1) / 3);
            res.green_m = 10'((4 * sum[1] + 1) / 3);
            res.blue_m  = 10'((4 * sum[2] + 1) / 3);
            res.col     = 11'(c - 1);
            res.row     = 12'(r - 1);
            res.last    = (r == h - 1) && (c == w - 1);
            pending_means.push_back(res);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // Send one pixel request; valid is held until taken.
    task automatic send_pixel(input rgb_t px);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red      <= px[0];
        green    <= px[1];
        blue     <= px[2];
        do @(posedge clk); while (!in_ready);
        predict_mean(px);
    endtask

    task automatic write_reg(input logic [tvmf_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= tvmf_pkg::CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        shadow_config(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain: every expected result in, then let the pipeline empty.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        wait_idle();
        write_reg(tvmf_pkg::REG_FRAME_WIDTH, w);
        write_reg(tvmf_pkg::REG_FRAME_HEIGHT, h);
    endtask

    function automatic rgb_t rand_pixel(input int palette_pct);
        rgb_t p;
        if ($urandom_range(99) < palette_pct)
            p = palette[$urandom_range(2)];
        else
            p = 24'($urandom);
        return p;
    endfunction

    // ---- directed tests ----

    // Smallest frame via clamped registers; channel extremes and full ties.
    task automatic test_extremes();
        rgb_t px [9];
        set_frame(0, 1);          // both clamp up to three
        px[0] = 24'h000000; px[1] = 24'hFFFFFF; px[2] = 24'h0000FF;
        px[3] = 24'h00FF00; px[4] = 24'hFF0000; px[5] = 24'hFFFFFF;
        px[6] = 24'hFFFFFF; px[7] = 24'hFFFFFF; px[8] = 24'h000000;
        for (int i = 0; i < 9; i++) send_pixel(px[i]);
        // identical pixels: all scores tie, lowest positions win
        for (int i = 0; i < 9; i++) send_pixel(24'h7F80FE);
    endtask

    // Width write with its upper bit set: dropped, leaving sixteen columns.
    task automatic test_wide_frame();
        set_frame(13'h1010, 2);
        for (int i = 0; i < 16 * 3; i++) send_pixel(24'($urandom));
    endtask

    // Height clamped to its top, then lowered mid-frame so the row wraps.
    task automatic test_height_wrap();
        set_frame(3, 8191);
        for (int i = 0; i < 15; i++) send_pixel(24'($urandom));
        set_frame(3, 3);           // row 5 is beyond three: wraps to zero
        for (int i = 0; i < 9; i++) send_pixel(24'($urandom));
    endtask

    // Width lowered mid-frame: column wraps without advancing the row.
    task automatic test_width_wrap();
        set_frame(8, 6);
        for (int i = 0; i < 30; i++) send_pixel(rand_pixel(50));
        wait_idle();
        write_reg(tvmf_pkg::REG_FRAME_WIDTH, 4);
        for (int i = 0; i < 12; i++) send_pixel(rand_pixel(50));
    endtask

    // ---- random test: whole frames, small sizes, several idling modes ----
    task automatic test_random_frames(input int idle_pct, input int stall, input int n_items);
        int sent, w, h, pause_at;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(20, 64) : $urandom_range(3, 10);
            h = $urandom_range(3, 7);
            set_frame(w, h);
            for (int k = 0; k < 3; k++) palette[k] = 24'($urandom);
            pause_at = $urandom_range(w * h - 1);
            for (int i = 0; i < w * h; i++)
            begin
                // occasionally the sender holds off until all results are in
                if (i == pause_at && $urandom_range(3) == 0)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (pending_means.size() != 0) @(posedge clk);
                end
                send_pixel(rand_pixel(40));
            end
            sent += w * h;
        end
    endtask

    // ---- receiver: random back-pressure ----
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // ---- result checker ----
    always @(posedge clk)
    begin
        mean_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_means.size() == 0)
            begin
                report_mismatch("unexpected result request", 1, 0);
            end
            else
            begin
                want = pending_means.pop_front();
                if (red_mean !== want.red_m)   report_mismatch("red_mean", red_mean, want.red_m);
                if (green_mean !== want.green_m)
                    report_mismatch("green_mean", green_mean, want.green_m);
                if (blue_mean !== want.blue_m) report_mismatch("blue_mean", blue_mean, want.blue_m);
                if (out_col !== want.col)      report_mismatch("out_col", out_col, want.col);
                if (out_row !== want.row)      report_mismatch("out_row", out_row, want.row);
                if (last_of_frame !== want.last)
                    report_mismatch("last_of_frame", last_of_frame, want.last);
            end
        end
    end

    // ---- watchdog: cycles with no handshake on any channel ----
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        red       = '0;
        green     = '0;
        blue      = '0;
        for (int i = 0; i < 9; i++) win[i] = '0;
        for (int i = 0; i < 2048; i++)
        begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = tvmf_pkg::FW_RESET;
        height_reg = tvmf_pkg::FH_RESET;
        for (int k = 0; k < 3; k++) palette[k] = 24'($urandom);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_wide_frame();
        test_height_wrap();
        test_width_wrap();
        test_random_frames(0, 0, 420);
        test_random_frames(73, 0, 420);
        test_random_frames(0, 73, 420);
        test_random_frames(37, 37, 420);

        wait_idle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
